FILE: hdl/cssv_pkg.sv
// Shared types, character constants and class helpers for the callsign shape validator.
`timescale 1ns / 1ps

package cssv_pkg;

  localparam int unsigned STORE_DEPTH = 9;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned CALL_W      = STORE_DEPTH * CHAR_W;

  localparam logic [3:0] DEPTH_LEN  = 4'd9;
  localparam logic [3:0] BASE_MIN   = 4'd3;
  localparam logic [3:0] BASE_MAX   = 4'd7;
  localparam logic [3:0] SUFFIX_MAX = 4'd4;
  localparam logic [3:0] COUNT_MAX  = 4'd15;
  localparam logic [3:0] SSID_MAX   = 4'd2;

  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_DASH   = 8'h2D;

  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic              valid_res;
    logic [CALL_W-1:0] callsign;
    logic [3:0]        length;
  } out_beat_t;

  function automatic logic is_upper(input logic [7:0] c);
    return c inside {[CHAR_UP_A:CHAR_UP_Z]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CHAR_ZERO:CHAR_NINE]};
  endfunction

endpackage

FILE: hdl/callsign_shape_validator.sv
// Top level of the callsign shape validator: input register, name state and result register.
`timescale 1ns / 1ps

// Callsign shape validator. Feed a station name one character per beat on the in_
// channel, first character first, with is_last set on the final character. Lower-case
// letters are folded to upper case. On the last character the block delivers one
// result beat on the out_ channel: valid_res says whether the name is a legal
// amateur callsign (letters, digits and dash only; a base call of 3 to 7 characters
// made of a 1 to 2 character prefix holding a letter, one call-area digit and 1 to 4
// letters; an optional SSID after the first dash of 1 to 2 letters or digits that is
// not "0"; at most 9 characters in all), callsign holds the upper-cased name at seven
// bits per character (character i in bits 7i+6..7i) and length its character count;
// both read zero when the name is invalid. Characters that are not last produce no
// beat. Throughput is one character per cycle except while a last character waits on a
// stalled result: the checks run in one pass of logic between the input register and
// the result register, so a last character passes from the input register straight
// into the result register, which drives out_valid. in_ready drops only while a last
// character waits behind a result that out_ready has not yet taken. There is no
// clearing pass after reset; the character store is only read at entries written
// for the current name.
module callsign_shape_validator
  import cssv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  // Input register: holds one accepted character beat.
  logic     in_valid_r;
  in_beat_t in_beat_r;

  // Per-name state.
  logic [CHAR_W-1:0] store_r [STORE_DEPTH];
  logic [3:0]        count_r;
  logic              failed_r;
  logic              dash_seen_r;
  logic [3:0]        dash_pos_r;

  // Result register.
  logic      out_valid_r;
  out_beat_t out_data_r;

  logic advance;

  // A character that is not last never waits; a last one needs room in the
  // result register.
  assign advance  = in_valid_r && (!in_beat_r.is_last || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // ---------------------------------------------------------------------------
  // Character fold and state update.
  // ---------------------------------------------------------------------------
  logic [7:0]        c_fold;
  logic [CHAR_W-1:0] c7;
  logic              char_ok;
  logic              in_range;
  logic              failed_nxt;
  logic              dash_seen_nxt;
  logic [3:0]        dash_pos_nxt;
  logic [3:0]        count_nxt;
  logic [CHAR_W-1:0] view [STORE_DEPTH];

  always_comb begin
    if (in_beat_r.character inside {[CHAR_LO_A:CHAR_LO_Z]}) begin
      c_fold = in_beat_r.character - CASE_OFFSET;
    end else begin
      c_fold = in_beat_r.character;
    end
    c7       = c_fold[CHAR_W-1:0];
    char_ok  = is_upper(c_fold) || is_digit(c_fold) || (c_fold == CHAR_DASH);
    in_range = count_r < DEPTH_LEN;

    failed_nxt = failed_r || !char_ok || !in_range;

    // Only the first dash splits base call and SSID.
    if ((c_fold == CHAR_DASH) && !dash_seen_r) begin
      dash_seen_nxt = 1'b1;
      dash_pos_nxt  = count_r;
    end else begin
      dash_seen_nxt = dash_seen_r;
      dash_pos_nxt  = dash_pos_r;
    end

    // Saturate the count so an overlong name stays flagged.
    count_nxt = (count_r < COUNT_MAX) ? count_r + 4'd1 : count_r;

    // Store as it looks with this character written in.
    for (int k = 0; k < STORE_DEPTH; k++) begin
      view[k] = (in_range && (count_r == 4'(k))) ? c7 : store_r[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Name checks, evaluated on the last character.
  // ---------------------------------------------------------------------------
  logic [3:0]        n;
  logic [3:0]        cl;
  logic [3:0]        sl;
  logic [3:0]        zero_idx;
  logic [CHAR_W-1:0] zero_char;
  logic              len_ok;
  logic              ssid_ok;
  logic              ssid_dash_bad;
  logic              base_ok;
  logic              name_ok;
  logic [CALL_W-1:0] packed_call;

  always_comb begin
    logic       pat_ok;
    logic       has_alpha;
    logic [3:0] suf;

    n  = count_nxt;
    cl = dash_seen_nxt ? dash_pos_nxt : n;

    len_ok = !failed_nxt && (n <= DEPTH_LEN) && (cl >= BASE_MIN) && (cl <= BASE_MAX);

    // SSID: 1 to 2 characters after the first dash, no second dash, not "0".
    sl       = (n > cl) ? n - cl - 4'd1 : 4'd0;
    zero_idx = cl + 4'd1;
    zero_char     = '0;
    ssid_dash_bad = 1'b0;
    for (int k = 0; k < STORE_DEPTH; k++) begin
      if (zero_idx == 4'(k)) begin
        zero_char = view[k];
      end
      if ((4'(k) > cl) && (4'(k) < n) && ({1'b0, view[k]} == CHAR_DASH)) begin
        ssid_dash_bad = 1'b1;
      end
    end
    ssid_ok = !dash_seen_nxt ||
              ((n > cl) && (sl >= 4'd1) && (sl <= SSID_MAX) && !ssid_dash_bad &&
               !((sl == 4'd1) && ({1'b0, zero_char} == CHAR_ZERO)));

    // Base call: prefix of one or two alphanumerics with a letter, the call-area
    // digit, then 1 to 4 letters up to the end of the base call.
    base_ok = 1'b0;
    for (int pl = 1; pl <= 2; pl++) begin
      pat_ok    = is_digit({1'b0, view[pl]});
      has_alpha = 1'b0;
      suf       = cl - 4'(pl) - 4'd1;
      if ((suf < 4'd1) || (suf > SUFFIX_MAX)) begin
        pat_ok = 1'b0;
      end
      for (int k = 0; k < STORE_DEPTH; k++) begin
        if (k < pl) begin
          if (is_upper({1'b0, view[k]})) begin
            has_alpha = 1'b1;
          end else if (!is_digit({1'b0, view[k]})) begin
            pat_ok = 1'b0;
          end
        end else if ((k > pl) && (4'(k) < cl) && !is_upper({1'b0, view[k]})) begin
          pat_ok = 1'b0;
        end
      end
      if (pat_ok && has_alpha) begin
        base_ok = 1'b1;
      end
    end

    name_ok = len_ok && ssid_ok && base_ok;

    for (int k = 0; k < STORE_DEPTH; k++) begin
      packed_call[k*CHAR_W +: CHAR_W] = (name_ok && (4'(k) < n)) ? view[k] : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      count_r     <= '0;
      failed_r    <= 1'b0;
      dash_seen_r <= 1'b0;
      dash_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        if (in_beat_r.is_last) begin
          // Drop the name state; the store needs no clearing.
          count_r     <= '0;
          failed_r    <= 1'b0;
          dash_seen_r <= 1'b0;
          dash_pos_r  <= '0;
        end else begin
          count_r     <= count_nxt;
          failed_r    <= failed_nxt;
          dash_seen_r <= dash_seen_nxt;
          dash_pos_r  <= dash_pos_nxt;
        end
      end
      // Load a new result beat, or hold the stalled one.
      out_valid_r <= (advance && in_beat_r.is_last) || (out_valid_r && !out_ready);
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_beat_r <= in_data;
    end
    if (advance && in_range) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
        if (count_r == 4'(k)) begin
          store_r[k] <= c7;
        end
      end
    end
    if (advance && in_beat_r.is_last) begin
      out_data_r.valid_res <= name_ok;
      out_data_r.callsign  <= packed_call;
      out_data_r.length    <= name_ok ? n : 4'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/cssv_checker.sv
// Port-level checker for the callsign shape validator and its bind.
`timescale 1ns / 1ps

module cssv_checker
  import cssv_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Input back-pressure only comes from a stalled result beat.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // An invalid name carries no callsign and no length.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> (out_data.callsign == '0) && (out_data.length == 4'd0))
    else $error("invalid result with nonzero payload");

  // A valid callsign is 3 to 9 characters long.
  a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_res |-> (out_data.length >= BASE_MIN) &&
                                        (out_data.length <= DEPTH_LEN))
    else $error("valid result with illegal length");

  // No character bits above the reported length.
  a_valid_pack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_res |-> ((out_data.callsign >> (7 * out_data.length)) == '0))
    else $error("callsign bits beyond length");

endmodule

bind callsign_shape_validator cssv_checker u_cssv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/tb_callsign_shape_validator.sv
// Self-checking testbench for the callsign shape validator: predicts each name's verdict.
`timescale 1ns / 1ps

module tb_callsign_shape_validator;
  import cssv_pkg::*;

  // Stimulus budget and run limits. A name's last character passes through the input
  // register into the result register, so a short settle window is enough after the final result.
  localparam int unsigned RANDOM_ITEMS  = 1020;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef logic [7:0] char_q_t[$];

  // Ways to damage a well-formed callsign before sending it.
  typedef enum int unsigned {
    MUT_BYTE,
    MUT_DASH,
    MUT_DROP,
    MUT_GROW
  } mutation_e;

  // Verdict predictor and store of due verdicts. Tracks the current name the same way
  // the block does: stored characters, a saturating length, a sticky bad-name flag and
  // the index of the first dash.
  class callsign_verdicts;
    logic [6:0]  name_chars [STORE_DEPTH];
    int unsigned name_len   = 0;
    bit          bad_char   = 0;
    bit          dash_found = 0;
    int unsigned first_dash = 0;
    out_beat_t   due_verdicts[$];
    int unsigned errors     = 0;

    function bit upper_letter(logic [7:0] c);
      return (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
    endfunction

    function bit numeral(logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function int unsigned pending();
      return due_verdicts.size();
    endfunction

    // Apply every callsign rule to the name collected so far.
    function bit shape_ok();
      int n;
      int base_len;
      int ssid_len;
      int start;
      int suffix_len;
      int prefix_len;
      bit has_letter;
      n = int'(name_len);
      has_letter = 1'b0;
      if (bad_char || n > int'(STORE_DEPTH)) return 1'b0;
      base_len = dash_found ? int'(first_dash) : n;
      if (base_len < int'(BASE_MIN) || base_len > int'(BASE_MAX)) return 1'b0;
      if (dash_found) begin
        ssid_len = n - base_len - 1;
        if (ssid_len < 1 || ssid_len > int'(SSID_MAX)) return 1'b0;
        // Any dash after the first one lands in the SSID.
        for (int i = base_len + 1; i < n; i++) begin
          if (name_chars[i] == CHAR_DASH[6:0]) return 1'b0;
        end
        if (ssid_len == 1 && name_chars[base_len + 1] == CHAR_ZERO[6:0]) return 1'b0;
      end
      // Walk back over the letter suffix, then expect the call-area digit.
      start = base_len;
      while (start > 0 && upper_letter({1'b0, name_chars[start - 1]})) start--;
      suffix_len = base_len - start;
      if (suffix_len < 1 || suffix_len > int'(SUFFIX_MAX) || start == 0) return 1'b0;
      if (!numeral({1'b0, name_chars[start - 1]})) return 1'b0;
      prefix_len = start - 1;
      if (prefix_len < 1 || prefix_len > 2) return 1'b0;
      for (int i = 0; i < prefix_len; i++) begin
        if (upper_letter({1'b0, name_chars[i]})) has_letter = 1'b1;
        else if (!numeral({1'b0, name_chars[i]})) return 1'b0;
      end
      return has_letter;
    endfunction

    // Take one accepted input beat; on the last character queue the verdict.
    function void note_char(in_beat_t beat);
      logic [7:0] c;
      out_beat_t  verdict;
      c = beat.character;
      if (c >= CHAR_LO_A && c <= CHAR_LO_Z) c = c - CASE_OFFSET;
      if (!(upper_letter(c) || numeral(c) || c == CHAR_DASH)) bad_char = 1'b1;
      if (name_len < STORE_DEPTH) name_chars[name_len] = c[6:0];
      else bad_char = 1'b1;
      if (c == CHAR_DASH && !dash_found) begin
        dash_found = 1'b1;
        first_dash = name_len;
      end
      if (name_len < COUNT_MAX) name_len++;
      if (beat.is_last) begin
        verdict = '0;
        if (shape_ok()) begin
          verdict.valid_res = 1'b1;
          verdict.length    = name_len[3:0];
          for (int i = 0; i < int'(name_len); i++) begin
            verdict.callsign[7*i +: 7] = name_chars[i];
          end
        end
        due_verdicts.push_back(verdict);
        name_len   = 0;
        bad_char   = 1'b0;
        dash_found = 1'b0;
        first_dash = 0;
      end
    endfunction

    // Compare one accepted result beat with the oldest due verdict.
    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (due_verdicts.size() == 0) begin
        $error("result beat with no verdict due: valid_res %0b callsign %h length %0d",
               got.valid_res, got.callsign, got.length);
        errors++;
        return;
      end
      want = due_verdicts.pop_front();
      if (got.valid_res !== want.valid_res) begin
        $error("valid_res mismatch: expected %0b, actual %0b", want.valid_res, got.valid_res);
        errors++;
      end
      if (got.callsign !== want.callsign) begin
        $error("callsign mismatch: expected %h, actual %h", want.callsign, got.callsign);
        errors++;
      end
      if (got.length !== want.length) begin
        $error("length mismatch: expected %0d, actual %0d", want.length, got.length);
        errors++;
      end
    endfunction
  endclass

  // Every block input starts at a known value.
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  callsign_verdicts verdicts = new;

  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;
  logic [5:0]  ready_phase = '0;
  int unsigned ready_mode  = 0;

  callsign_shape_validator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: each time the phase counter wraps, switch stall behavior among always ready,
  // coin flip, mostly stalled and a square wave, so back-pressure lands on every phase.
  always @(posedge clk) begin
    ready_phase <= ready_phase + 1'b1;
    if (ready_phase == '0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= ready_phase[2];
      end
    endcase
  end

  // Monitor both channels on the edge where each beat is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) verdicts.note_char(in_data);
      if (out_valid && out_ready) verdicts.check_beat(out_data);
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = CHAR_UP_A + 8'($urandom_range(0, 25));
    // Fold some letters down so the case fold gets exercised throughout.
    if ($urandom_range(0, 3) == 0) c = c + CASE_OFFSET;
    return c;
  endfunction

  function automatic logic [7:0] rand_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic char_q_t from_text(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Build a callsign-shaped name: prefix, call-area digit, letter suffix, optional SSID.
  // Prefixes may come out all digits, which keeps the no-letter rule in play.
  function automatic char_q_t random_callsign();
    char_q_t     q;
    int unsigned prefix_len;
    int unsigned suffix_len;
    int unsigned ssid_len;
    prefix_len = $urandom_range(1, 2);
    repeat (prefix_len) q.push_back(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
    q.push_back(rand_digit());
    suffix_len = $urandom_range(1, 4);
    repeat (suffix_len) q.push_back(rand_letter());
    if ($urandom_range(0, 1) == 1) begin
      q.push_back(CHAR_DASH);
      if ($urandom_range(0, 7) == 0) begin
        q.push_back(CHAR_ZERO);
      end else begin
        ssid_len = $urandom_range(1, 2);
        repeat (ssid_len) q.push_back(($urandom_range(0, 1) == 1) ? rand_digit() : rand_letter());
      end
    end
    return q;
  endfunction

  function automatic char_q_t mutate(char_q_t q);
    int unsigned pos;
    pos = $urandom_range(0, q.size() - 1);
    case (mutation_e'($urandom_range(0, 3)))
      MUT_BYTE: begin
        q[pos] = 8'($urandom_range(1, 255));
      end
      MUT_DASH: begin
        q.insert(pos, CHAR_DASH);
      end
      MUT_DROP: begin
        if (q.size() > 1) q.delete(pos);
      end
      default: begin
        q.push_back(rand_letter());
      end
    endcase
    return q;
  endfunction

  // Free-form noise: any byte, heavy on dashes, long enough to saturate the count.
  function automatic char_q_t noise_name();
    char_q_t     q;
    int unsigned len;
    len = $urandom_range(1, 17);
    repeat (len) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: q.push_back(8'($urandom_range(1, 255)));
        5, 6:          q.push_back(rand_letter());
        7:             q.push_back(rand_digit());
        default:       q.push_back(CHAR_DASH);
      endcase
    end
    return q;
  endfunction

  // Send one character beat. Between bursts drop valid for a random gap; within a
  // burst keep valid high so back-to-back beats go out every cycle while in_ready holds.
  task automatic send_char(input in_beat_t beat);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    // Hold the beat until the block takes it.
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_name(input char_q_t name);
    in_beat_t beat;
    for (int i = 0; i < name.size(); i++) begin
      beat.character = name[i];
      beat.is_last   = (i == name.size() - 1);
      send_char(beat);
    end
  endtask

  // Stop sending and wait for every due verdict to come back, plus a settle window.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    char_q_t     name;
    int unsigned pick;
    bit          pressure_done;
    pressure_done = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed names: shortest legal base in lower case, a digit-led prefix with a
    // two-character SSID at the full nine characters, an SSID of just zero, a second
    // dash, a lone byte outside the alphabet, and a name one character too long.
    send_name(from_text("k1a"));
    send_name(from_text("2e0abc-15"));
    send_name(from_text("K1A-0"));
    send_name(from_text("K1A--"));
    name = {8'hFF};
    send_name(name);
    send_name(from_text("AB1CDEF-12"));

    // Random names: mostly callsign-shaped with random content, some damaged, the
    // rest noise. Halfway through, hold off until everything outstanding has returned.
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        name = random_callsign();
      end else if (pick < 80) begin
        name = mutate(random_callsign());
      end else begin
        name = noise_name();
      end
      if (!pressure_done && items_sent > RANDOM_ITEMS / 2) begin
        drain_results();
        pressure_done = 1'b1;
      end
      send_name(name);
    end

    drain_results();
    if (verdicts.errors == 0 && verdicts.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
